// File: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define GZMD_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define GZMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// property whose consequent must hold in the same cycle as the antecedent
`define GZMD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/gzmd_pkg.sv
package gzmd_pkg;

	localparam logic [7:0] GZMD_MAGIC0        = 8'h1F;
	localparam logic [7:0] GZMD_MAGIC1        = 8'h8B;
	localparam logic [7:0] GZMD_METHOD        = 8'h08;
	localparam logic [7:0] GZMD_RESERVED_MASK = 8'hE0;
	localparam logic [7:0] GZMD_FLG_EXTRA     = 8'h04;
	localparam logic [7:0] GZMD_FLG_NAME      = 8'h08;
	localparam logic [7:0] GZMD_FLG_COMMENT   = 8'h10;
	localparam logic [7:0] GZMD_FLG_HCRC      = 8'h02;

	// last index of the ten-byte fixed header
	localparam logic [3:0] GZMD_FIXED_LAST = 4'd9;
	// shortest member that can be well formed
	localparam logic [4:0] GZMD_MIN_MEMBER = 5'd18;
	// trailer length, also the depth of the payload delay line
	localparam int         GZMD_TAIL_LEN   = 8;
	localparam logic [3:0] GZMD_TAIL_FULL  = 4'(GZMD_TAIL_LEN);

	// default depth of the result queue (at least two)
	localparam int GZMD_RES_DEPTH = 4;

	typedef enum logic [2:0] {
		PH_FIXED   = 3'd0,
		PH_XLEN    = 3'd1,
		PH_XDATA   = 3'd2,
		PH_NAME    = 3'd3,
		PH_COMMENT = 3'd4,
		PH_HCRC    = 3'd5,
		PH_PAYLOAD = 3'd6,
		PH_HALT    = 3'd7
	} gzmd_phase_t;

	typedef enum logic [3:0] {
		ST_OK       = 4'd0,
		ST_SHORT    = 4'd1,
		ST_MAGIC    = 4'd2,
		ST_METHOD   = 4'd3,
		ST_RESERVED = 4'd4,
		ST_XLEN     = 4'd5,
		ST_XPAYLOAD = 4'd6,
		ST_NAME     = 4'd7,
		ST_COMMENT  = 4'd8,
		ST_HCRC     = 4'd9,
		ST_TRAILER  = 4'd10
	} gzmd_status_t;

	typedef struct packed {
		gzmd_phase_t  phase;
		logic [3:0]   hidx;
		logic [7:0]   flags;
		logic [15:0]  xrem;
		logic [7:0]   xlow;
		gzmd_status_t err;
		logic [4:0]   cnt;
		logic [3:0]   fill;
	} gzmd_state_t;

	localparam gzmd_state_t GZMD_STATE_RESET = '{
		phase: PH_FIXED,
		hidx:  4'd0,
		flags: 8'd0,
		xrem:  16'd0,
		xlow:  8'd0,
		err:   ST_OK,
		cnt:   5'd0,
		fill:  4'd0
	};

	typedef struct packed {
		logic         kind;
		logic [7:0]   payload_byte;
		gzmd_status_t status;
		logic [31:0]  crc;
		logic [31:0]  size;
		logic         eor;
	} gzmd_result_t;

	// results produced by one byte, in delivery order
	typedef struct packed {
		logic [1:0]   n;
		gzmd_result_t a;
		gzmd_result_t b;
	} gzmd_push_t;

	// first enabled optional section after the given one
	function automatic gzmd_phase_t next_section(input gzmd_phase_t from,
			input logic [7:0] flags);
		gzmd_phase_t ph;
		ph = PH_PAYLOAD;
		if (from < PH_HCRC && (flags & GZMD_FLG_HCRC) != 8'd0) ph = PH_HCRC;
		if (from < PH_COMMENT && (flags & GZMD_FLG_COMMENT) != 8'd0) ph = PH_COMMENT;
		if (from < PH_NAME && (flags & GZMD_FLG_NAME) != 8'd0) ph = PH_NAME;
		if (from < PH_XLEN && (flags & GZMD_FLG_EXTRA) != 8'd0) ph = PH_XLEN;
		return ph;
	endfunction

endpackage

// File: rtl/core/gzmd_step.sv
module gzmd_step import gzmd_pkg::*; (
	input  gzmd_state_t                    cur,
	input  logic [GZMD_TAIL_LEN-1:0][7:0]  tail,
	input  logic [7:0]                     in_byte,
	input  logic                           final_byte,
	output gzmd_state_t                    nxt,
	output gzmd_push_t                     push
);

	logic                          hdr_err;
	gzmd_status_t                  err_code;
	logic                          emit;
	logic [15:0]                   xrem_dec;
	logic [GZMD_TAIL_LEN-1:0][7:0] tail_new;
	gzmd_state_t                   upd;
	gzmd_status_t                  st;
	gzmd_result_t                  pay_res;
	gzmd_result_t                  rep_res;

	assign xrem_dec = cur.xrem - 16'd1;
	assign tail_new = {in_byte, tail[GZMD_TAIL_LEN-1:1]};

	// header walk and delay bookkeeping
	always_comb begin
		upd      = cur;
		hdr_err  = 1'b0;
		err_code = ST_OK;
		emit     = 1'b0;
		if (cur.cnt < GZMD_MIN_MEMBER) upd.cnt = cur.cnt + 5'd1;
		if (cur.phase == PH_PAYLOAD) begin
			if (cur.fill >= GZMD_TAIL_FULL) begin
				emit = 1'b1;
			end else begin
				upd.fill = cur.fill + 4'd1;
			end
		end else begin
			case (cur.phase)
				PH_FIXED: begin
					if (cur.hidx == 4'd0 && in_byte != GZMD_MAGIC0) begin
						hdr_err  = 1'b1;
						err_code = ST_MAGIC;
					end else if (cur.hidx == 4'd1 && in_byte != GZMD_MAGIC1) begin
						hdr_err  = 1'b1;
						err_code = ST_MAGIC;
					end else if (cur.hidx == 4'd2 && in_byte != GZMD_METHOD) begin
						hdr_err  = 1'b1;
						err_code = ST_METHOD;
					end else if (cur.hidx == 4'd3) begin
						if ((in_byte & GZMD_RESERVED_MASK) != 8'd0) begin
							hdr_err  = 1'b1;
							err_code = ST_RESERVED;
						end else begin
							upd.flags = in_byte;
						end
					end
					if (!hdr_err) begin
						if (cur.hidx >= GZMD_FIXED_LAST) begin
							upd.hidx  = 4'd0;
							upd.phase = next_section(PH_FIXED, cur.flags);
						end else begin
							upd.hidx = cur.hidx + 4'd1;
						end
					end
				end
				PH_XLEN: begin
					if (cur.hidx == 4'd0) begin
						upd.xlow = in_byte;
						upd.hidx = 4'd1;
					end else begin
						upd.hidx  = 4'd0;
						upd.xrem  = {in_byte, cur.xlow};
						upd.phase = ({in_byte, cur.xlow} != 16'd0) ? PH_XDATA
							: next_section(PH_XDATA, cur.flags);
					end
				end
				PH_XDATA: begin
					upd.xrem = xrem_dec;
					if (xrem_dec == 16'd0) upd.phase = next_section(PH_XDATA, cur.flags);
				end
				PH_NAME: begin
					if (in_byte == 8'd0) upd.phase = next_section(PH_NAME, cur.flags);
				end
				PH_COMMENT: begin
					if (in_byte == 8'd0) upd.phase = next_section(PH_COMMENT, cur.flags);
				end
				PH_HCRC: begin
					if (cur.hidx == 4'd0) begin
						upd.hidx = 4'd1;
					end else begin
						upd.hidx  = 4'd0;
						upd.phase = PH_PAYLOAD;
					end
				end
				default: begin
				end
			endcase
			if (hdr_err) begin
				if (cur.err == ST_OK) upd.err = err_code;
				upd.phase = PH_HALT;
			end
		end
	end

	// member done: back to the start for the next one
	assign nxt = final_byte ? GZMD_STATE_RESET : upd;

	// end-of-member status from the state after this byte: short first,
	// then the first header fault, then an open section, then a cut trailer
	always_comb begin
		if (upd.cnt < GZMD_MIN_MEMBER) begin
			st = ST_SHORT;
		end else if (upd.err != ST_OK) begin
			st = upd.err;
		end else begin
			case (upd.phase)
				PH_XLEN:    st = ST_XLEN;
				PH_XDATA:   st = ST_XPAYLOAD;
				PH_NAME:    st = ST_NAME;
				PH_COMMENT: st = ST_COMMENT;
				PH_HCRC:    st = ST_HCRC;
				PH_PAYLOAD: st = (upd.fill < GZMD_TAIL_FULL) ? ST_TRAILER : ST_OK;
				default:    st = ST_TRAILER;
			endcase
		end
	end

	always_comb begin
		pay_res              = '0;
		pay_res.kind         = 1'b0;
		pay_res.payload_byte = tail[0];
		pay_res.status       = ST_OK;
		pay_res.eor          = !final_byte;
		rep_res              = '0;
		rep_res.kind         = 1'b1;
		rep_res.status       = st;
		rep_res.eor          = 1'b1;
		if (st == ST_OK) begin
			rep_res.crc  = tail_new[3:0];
			rep_res.size = tail_new[7:4];
		end
		push = '0;
		if (emit) begin
			push.a = pay_res;
			push.b = rep_res;
			push.n = final_byte ? 2'd2 : 2'd1;
		end else begin
			push.a = rep_res;
			push.b = rep_res;
			push.n = final_byte ? 2'd1 : 2'd0;
		end
	end

endmodule

// File: rtl/core/gzmd_result_fifo.sv
module gzmd_result_fifo import gzmd_pkg::*; #(
	parameter  int DEPTH = GZMD_RES_DEPTH,
	localparam int CW    = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  gzmd_result_t  wr_a,
	input  gzmd_result_t  wr_b,
	input  logic          pop,
	output gzmd_result_t  rd_data,
	output logic [CW-1:0] count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	gzmd_result_t   mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic [AW-1:0]  wr_ptr_p1;
	logic [AW-1:0]  wr_ptr_p2;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
	endfunction

	assign wr_ptr_p1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_p2 = ptr_inc(wr_ptr_p1);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_ptr_q] <= wr_a;
		if (push_n == 2'd2) mem_q[wr_ptr_p1] <= wr_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push_n)
				2'd1:    wr_ptr_q <= wr_ptr_p1;
				2'd2:    wr_ptr_q <= wr_ptr_p2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			count_q <= CW'(count_q + CW'(push_n) - CW'(pop));
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign count   = count_q;

endmodule

// File: rtl/core/gzip_member_deframer_core.sv
// channel   | beat holds                                        | handshake
// ----------+---------------------------------------------------+---------------------------
// byte in   | in_byte, final_byte                               | byte_valid / byte_ready
// result    | kind, payload_byte, status, trailer_crc,          | result_valid / result_ready
//           | trailer_size, end_of_run                          |
//
// one byte a cycle is taken while byte_ready is high; a byte's results are written
// to the result port's queue when the byte leaves the input stage
// a byte is registered, walked through the header logic and its results go into a
// queue of RES_DEPTH entries; the final byte after payload gives two result beats
// byte_ready drops while a byte waits and the queue holds more than RES_DEPTH-2 results
// arst_n clears the parse state, the input stage and the queue; no clearing pass
module gzip_member_deframer_core import gzmd_pkg::*; #(
	parameter int RES_DEPTH = GZMD_RES_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  in_byte,
	input  logic        final_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [3:0]  status,
	output logic [31:0] trailer_crc,
	output logic [31:0] trailer_size,
	output logic        end_of_run
);

	localparam int CW = $clog2(RES_DEPTH + 1);

	// input stage
	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          final_s1;

	// parse state and the payload delay line (oldest byte at index zero)
	gzmd_state_t                   state_q;
	gzmd_state_t                   state_nxt;
	logic [GZMD_TAIL_LEN-1:0][7:0] tail_q;

	gzmd_push_t                    push;
	logic [1:0]                    push_n;
	logic                          advance;
	logic [CW-1:0]                 res_count;
	gzmd_result_t                  res_head;
	logic                          pop;

	// the registered byte moves on only when two queue slots are free
	assign advance    = valid_s1 && (res_count <= CW'(RES_DEPTH - 2));
	assign byte_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && byte_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1  <= in_byte;
			final_s1 <= final_byte;
		end
	end

	gzmd_step u_step (
		.cur        (state_q),
		.tail       (tail_q),
		.in_byte    (byte_s1),
		.final_byte (final_s1),
		.nxt        (state_nxt),
		.push       (push)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= GZMD_STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// delay line has no reset: its bytes are read only once written
	always_ff @(posedge clk) begin
		if (advance) tail_q <= {byte_s1, tail_q[GZMD_TAIL_LEN-1:1]};
	end

	assign push_n = advance ? push.n : 2'd0;
	assign pop    = result_valid && result_ready;

	gzmd_result_fifo #(
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_n  (push_n),
		.wr_a    (push.a),
		.wr_b    (push.b),
		.pop     (pop),
		.rd_data (res_head),
		.count   (res_count)
	);

	assign result_valid = (res_count != '0);
	assign kind         = res_head.kind;
	assign payload_byte = res_head.payload_byte;
	assign status       = res_head.status;
	assign trailer_crc  = res_head.crc;
	assign trailer_size = res_head.size;
	assign end_of_run   = res_head.eor;

endmodule

// File: rtl/core/gzmd_checker.sv
`include "assert_macros.svh"

module gzmd_checker import gzmd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_ready,
	input logic        kind,
	input logic [3:0]  status,
	input logic [31:0] trailer_crc,
	input logic [31:0] trailer_size,
	input logic        end_of_run
);

	logic rep_v;
	logic trl_zero;
	assign rep_v    = result_valid && kind;
	assign trl_zero = (trailer_crc == '0) && (trailer_size == '0);

	// a waiting result beat is not withdrawn
	`GZMD_ASSERT_NEXT(a_res_hold, result_valid && !result_ready, result_valid, "result dropped")
	// payload beats carry no status or trailer
	`GZMD_ASSERT_SAME(a_pay_clean, result_valid && !kind, status == ST_OK && trl_zero, "dirty beat")
	// a report always closes the run of its byte
	`GZMD_ASSERT_SAME(a_rep_eor, rep_v, end_of_run, "report without end_of_run")
	// trailer fields only on a good member
	`GZMD_ASSERT_SAME(a_rep_trl, rep_v && status != ST_OK, trl_zero, "trailer on failed member")
	// status codes stay within the defined set
	`GZMD_ASSERT_ALWAYS(a_st_range, !result_valid || status <= ST_TRAILER, "status out of range")

endmodule

bind gzip_member_deframer_core gzmd_checker u_gzmd_checker (.*);
